// ----- hw/rtl/crtc_pkg.sv -----
// ----------------------------------------------------------------------------
// crtc_pkg
// Shared types and constants for the Catmull-Rom tone curve evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package crtc_pkg;
    localparam int MaxPoints    = 16;
    localparam int PtIdxW       = 4;
    localparam int MaxTableSize = 4096;
    localparam int FracBits     = 15;
    localparam int SizeW        = 13;
    localparam int CountW       = 5;
    localparam int EntryW       = 12;
    localparam int DivW         = 31;

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_EVAL = 1'b1;
    localparam logic [0:0] CFG_LUT_SIZE    = 1'b0;
    localparam logic [0:0] CFG_POINT_COUNT = 1'b1;

    typedef struct packed {
        logic        op;
        logic [3:0]  point_index;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [11:0] entry_index;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  curve_value;
        logic [11:0] entry_echo;
    } out_word_t;

    typedef enum logic [4:0] {
        CMD_IDLE   = 5'b00001,
        CMD_START  = 5'b00010,
        CMD_SEARCH = 5'b00100,
        CMD_DIV    = 5'b01000,
        CMD_POLY   = 5'b10000
    } cmd_phase_t;

    typedef struct packed {
        cmd_phase_t phase;
        logic       step;
        logic       finish;
    } dp_cmd_t;

    typedef struct packed {
        logic search_done;
        logic div_done;
        logic poly_done;
        logic identity;
    } dp_status_t;
endpackage
`default_nettype wire

// ----- hw/rtl/crtc_datapath.sv -----
// ----------------------------------------------------------------------------
// crtc_datapath
// Point table, segment search, shared restoring divider and Horner unit.
// ----------------------------------------------------------------------------
`default_nettype none
module crtc_datapath
    import crtc_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load_en,
    input  wire in_word_t        in_word,
    input  wire logic [SizeW-1:0]  lut_size,
    input  wire logic [CountW-1:0] point_count,
    input  wire dp_cmd_t         cmd,
    output dp_status_t           status,
    output out_word_t            result
);
    logic [15:0] px_mem [MaxPoints];
    logic [15:0] py_mem [MaxPoints];

    logic [11:0] size_m1_reg, ent_reg, echo_reg;
    logic [4:0]  n_reg;
    logic [3:0]  idx_reg;
    logic        ident_reg;
    logic [15:0] xq_reg;
    // divider
    logic [DivW-1:0] quo_reg;
    logic [DivW:0]   rem_reg;
    logic [DivW-1:0] dvd_reg;
    logic [16:0]     dvs_reg;
    logic [4:0]      cnt_reg;
    logic [1:0]      div_sel_reg;
    logic            div_done_reg;
    // poly
    logic signed [19:0] p1_reg, a1_reg, a2_reg, a3_reg;
    logic signed [39:0] acc_reg;
    logic [16:0]  t_reg;
    logic [1:0]   pstep_reg;
    logic [7:0]   val_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            px_mem[in_word.point_index] <= in_word.point_x;
            py_mem[in_word.point_index] <= in_word.point_y;
        end
    end

    logic [12:0] size_c;
    logic [4:0]  n_c;
    always_comb
    begin
        size_c = lut_size;
        if (size_c < 13'd2) size_c = 13'd2;
        if (size_c > 13'(MaxTableSize)) size_c = 13'(MaxTableSize);
        n_c = (point_count > 5'(MaxPoints)) ? 5'(MaxPoints) : point_count;
    end

    logic [3:0] nxt_idx, i0, i2, i3, last;
    logic       search_more;
    always_comb
    begin
        last    = 4'(n_reg - 5'd1);
        nxt_idx = idx_reg + 4'd1;
        search_more = ({1'b0, idx_reg} + 5'd1 < n_reg) && (px_mem[nxt_idx] < xq_reg);
        i0 = (idx_reg == 4'd0) ? 4'd0 : idx_reg - 4'd1;
        i2 = ({1'b0, idx_reg} + 5'd1 < n_reg) ? idx_reg + 4'd1 : last;
        i3 = ({1'b0, idx_reg} + 5'd2 < n_reg) ? idx_reg + 4'd2 : last;
    end

    logic [DivW:0] trial;
    logic [DivW:0] rsh;
    always_comb
    begin
        rsh   = {rem_reg[DivW-1:0], dvd_reg[DivW-1]};
        trial = rsh - {15'd0, dvs_reg};
    end

    logic signed [16:0] num_s, den_s;
    logic signed [19:0] p0, p1, p2, p3;
    always_comb
    begin
        num_s = $signed({1'b0, xq_reg}) - $signed({1'b0, px_mem[idx_reg]});
        den_s = $signed({1'b0, px_mem[i2]}) - $signed({1'b0, px_mem[idx_reg]});
        p0 = $signed({4'd0, py_mem[i0]});
        p1 = $signed({4'd0, py_mem[idx_reg]});
        p2 = $signed({4'd0, py_mem[i2]});
        p3 = $signed({4'd0, py_mem[i3]});
    end

    logic signed [39:0] prod, sh, nacc;
    logic signed [20:0] ysum;
    always_comb
    begin
        prod = acc_reg * $signed({1'b0, t_reg});
        sh   = prod >>> FracBits;
        case (pstep_reg)
            2'd0:    nacc = sh + 40'(a2_reg);
            2'd1:    nacc = sh + 40'(a1_reg);
            default: nacc = sh;
        endcase
        ysum = 21'(2 * p1_reg + 21'(acc_reg)) >>> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_done_reg <= 1'b0;
            pstep_reg    <= 2'd0;
            cnt_reg      <= 5'd0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            case (cmd.phase)
                CMD_START:
                begin
                    ent_reg     <= (in_word.entry_index > 12'(size_c - 13'd1)) ?
                                   12'(size_c - 13'd1) : in_word.entry_index;
                    echo_reg    <= in_word.entry_index;
                    size_m1_reg <= 12'(size_c - 13'd1);
                    n_reg       <= n_c;
                    ident_reg   <= (n_c < 5'd2);
                    idx_reg     <= 4'd0;
                    div_sel_reg <= 2'd0;
                    cnt_reg     <= 5'd0;
                    pstep_reg   <= 2'd0;
                end
                CMD_DIV:
                begin
                    if (div_done_reg)
                    begin
                        if (div_sel_reg == 2'd0)
                        begin
                            xq_reg  <= 16'(quo_reg);
                            val_reg <= 8'(quo_reg);
                        end
                        else
                        begin
                            if (num_s <= 17'sd0)
                                t_reg <= 17'd0;
                            else if (quo_reg > DivW'(32768))
                                t_reg <= 17'd32768;
                            else
                                t_reg <= 17'(quo_reg);
                            a3_reg <= -p0 + 20'sd3 * p1 - 20'sd3 * p2 + p3;
                            a2_reg <= 20'sd2 * p0 - 20'sd5 * p1 + 20'sd4 * p2 - p3;
                            a1_reg <= p2 - p0;
                            p1_reg <= p1;
                        end
                        div_sel_reg <= div_sel_reg + 2'd1;
                    end
                    else if (cnt_reg == 5'd0)
                    begin
                        rem_reg <= '0;
                        quo_reg <= '0;
                        cnt_reg <= 5'(DivW);
                        if (div_sel_reg == 2'd0)
                        begin
                            dvs_reg <= {5'd0, size_m1_reg};
                            dvd_reg <= ident_reg ? DivW'(ent_reg) * DivW'(255)
                                                 : DivW'({ent_reg, 15'd0});
                        end
                        else
                        begin
                            dvs_reg <= (den_s < 17'sd1) ? 17'd1 : 17'(den_s);
                            dvd_reg <= DivW'({num_s[15:0], 15'd0});
                        end
                    end
                    else
                    begin
                        if (!trial[DivW])
                        begin
                            rem_reg <= trial;
                            quo_reg <= {quo_reg[DivW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rsh;
                            quo_reg <= {quo_reg[DivW-2:0], 1'b0};
                        end
                        dvd_reg <= {dvd_reg[DivW-2:0], 1'b0};
                        cnt_reg <= cnt_reg - 5'd1;
                        if (cnt_reg == 5'd1)
                            div_done_reg <= 1'b1;
                    end
                end
                CMD_SEARCH:
                    if (search_more) idx_reg <= nxt_idx;
                CMD_POLY:
                begin
                    if (cmd.step)
                    begin
                        if (pstep_reg == 2'd0 && cnt_reg == 5'd0)
                        begin
                            acc_reg <= 40'(a3_reg);
                            cnt_reg <= 5'd1;
                        end
                        else if (pstep_reg != 2'd3)
                        begin
                            acc_reg   <= nacc;
                            pstep_reg <= pstep_reg + 2'd1;
                        end
                    end
                    if (cmd.finish)
                    begin
                        if (ysum < 0)
                            val_reg <= 8'd0;
                        else if (ysum > 21'sd32768)
                            val_reg <= 8'd255;
                        else
                            val_reg <= 8'((25'(ysum) * 25'd255) >> FracBits);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        status.search_done = !search_more;
        status.div_done    = div_done_reg;
        status.poly_done   = (pstep_reg == 2'd3);
        status.identity    = ident_reg;
        result.curve_value = val_reg;
        result.entry_echo  = echo_reg;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/crtc_control.sv -----
// ----------------------------------------------------------------------------
// crtc_control
// Sequencer: divide position, search, divide t, Horner, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module crtc_control
    import crtc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_op,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd,
    output logic            load_en
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIVX   = 7'b0000010,
        S_SEARCH = 7'b0000100,
        S_DIVT   = 7'b0001000,
        S_POLY   = 7'b0010000,
        S_FIN    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign load_en  = accept && (in_op == OP_LOAD);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd.phase  = CMD_IDLE;
        cmd.step   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            S_IDLE:
                if (accept && in_op == OP_EVAL)
                begin
                    cmd.phase  = CMD_START;
                    state_next = S_DIVX;
                end
            S_DIVX:
            begin
                cmd.phase = CMD_DIV;
                if (status.div_done)
                    state_next = status.identity ? S_OUT : S_SEARCH;
            end
            S_SEARCH:
            begin
                cmd.phase = CMD_SEARCH;
                if (status.search_done) state_next = S_DIVT;
            end
            S_DIVT:
            begin
                cmd.phase = CMD_DIV;
                if (status.div_done) state_next = S_POLY;
            end
            S_POLY:
            begin
                cmd.phase = CMD_POLY;
                cmd.step  = 1'b1;
                if (status.poly_done) state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.phase  = CMD_POLY;
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
                if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else        state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/catmull_rom_tone_curve_lut.sv -----
// Evaluate word: a restoring division for the position, the segment search, a
// second restoring division for t, then Horner evaluation and clamp before the
// result word; the identity ramp needs only the first division.
// Throughput: one word at a time, next word taken the cycle after the result
// word is accepted.
// Reset: asynchronous, active low; lut_size 256, point_count 0.
// ----------------------------------------------------------------------------
// catmull_rom_tone_curve_lut
// Tone curve table evaluator with Catmull-Rom interpolation.
// ----------------------------------------------------------------------------
`default_nettype none
module catmull_rom_tone_curve_lut
    import crtc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_word_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_word_t        out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic [SizeW-1:0]  lut_size_reg;
    logic [CountW-1:0] point_count_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       load_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lut_size_reg    <= 13'd256;
            point_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LUT_SIZE:    lut_size_reg    <= cfg_data[SizeW-1:0];
                CFG_POINT_COUNT: point_count_reg <= cfg_data[CountW-1:0];
                default: ;
            endcase
        end
    end

    crtc_control u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_op(in_data.op),
        .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .cmd(cmd), .load_en(load_en)
    );

    crtc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .load_en(load_en), .in_word(in_data),
        .lut_size(lut_size_reg), .point_count(point_count_reg),
        .cmd(cmd), .status(status), .result(out_data)
    );
endmodule
`default_nettype wire

// ----- hw/rtl/crtc_checker.sv -----
// ----------------------------------------------------------------------------
// crtc_checker
// Port-level checks of the tone curve evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
module crtc_checker
    import crtc_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_word_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("duplicate result word");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !out_valid)
        else $error("input word accepted beside a result word");
endmodule

bind catmull_rom_tone_curve_lut crtc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Catmull-Rom tone curve evaluator.
// A queue-fed driver offers load and evaluate words, a monitor checks each
// result word against a local spline predictor, and the curve settings are
// changed between phases while the block is drained. Both sides idle and
// stall at random, and one phase holds the output off to back up the input.
// ----------------------------------------------------------------------------
module tb;
    import crtc_pkg::*;

    localparam int WatchLimit = 20000;
    localparam int InW        = $bits(in_word_t);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = CFG_LUT_SIZE;
    logic [15:0] cfg_data = '0;

    in_word_t    pend_q[$];
    out_word_t   curve_q[$];
    logic [15:0] knot_x[MaxPoints];
    logic [15:0] knot_y[MaxPoints];
    logic [12:0] tbl_size = 13'd256;
    logic [4:0]  knot_cnt = 5'd0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_len = 0;
    int          hold_left = 0;
    int          fails = 0;
    int          quiet = 0;

    catmull_rom_tone_curve_lut DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] curve_of(logic [11:0] entry);
        longint one, size, n, i, xq, x1, x2, num, den, t;
        longint p0, p1, p2, p3, a1, a2, a3, acc, y;
        int     idx, i0, i2, i3;
        one  = longint'(1) << FracBits;
        size = longint'(tbl_size);
        n    = longint'(knot_cnt);
        i    = longint'(entry);
        if (size < 2) size = 2;
        if (size > MaxTableSize) size = MaxTableSize;
        if (n > MaxPoints) n = MaxPoints;
        if (i > size - 1) i = size - 1;
        if (n < 2) return 8'((i * 255) / (size - 1));
        xq = (i << FracBits) / (size - 1);
        idx = 0;
        while (idx + 1 < n && longint'(knot_x[idx + 1]) < xq) idx++;
        i0 = (idx == 0) ? 0 : idx - 1;
        i2 = (idx + 1 < n) ? idx + 1 : int'(n) - 1;
        i3 = (idx + 2 < n) ? idx + 2 : int'(n) - 1;
        x1  = longint'(knot_x[idx]);
        x2  = longint'(knot_x[i2]);
        num = xq - x1;
        den = x2 - x1;
        if (den < 1) den = 1;
        if (num <= 0)
        begin
            t = 0;
        end
        else
        begin
            t = (num << FracBits) / den;
            if (t > one) t = one;
        end
        p0 = longint'(knot_y[i0]);
        p1 = longint'(knot_y[idx]);
        p2 = longint'(knot_y[i2]);
        p3 = longint'(knot_y[i3]);
        a3 = -p0 + 3 * p1 - 3 * p2 + p3;
        a2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        a1 = p2 - p0;
        acc = ((a3 * t) >>> FracBits) + a2;
        acc = ((acc * t) >>> FracBits) + a1;
        acc = (acc * t) >>> FracBits;
        y = (2 * p1 + acc) >>> 1;
        if (y < 0) y = 0;
        if (y > one) y = one;
        return 8'((y * 255) >> FracBits);
    endfunction

    // driver: prediction happens when a word is accepted
    always @(posedge clk)
    begin
        in_word_t  w;
        out_word_t r;
        logic      nv;
        w  = in_data;
        nv = in_valid;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (in_data.op == OP_LOAD)
                begin
                    knot_x[in_data.point_index] = in_data.point_x;
                    knot_y[in_data.point_index] = in_data.point_y;
                end
                else
                begin
                    r.curve_value = curve_of(in_data.entry_index);
                    r.entry_echo  = in_data.entry_index;
                    curve_q = {curve_q, r};
                end
                nv = 1'b0;
            end
            if (!nv && pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                w  = pend_q.pop_front();
                nv = 1'b1;
            end
        end
        in_valid <= nv;
        in_data  <= w;
    end

    // monitor
    always @(posedge clk)
    begin
        out_word_t e;
        logic      st;
        if (rst_n && out_valid && !out_stall)
        begin
            if (curve_q.size() == 0)
            begin
                $error("unexpected result word: echo %0d value %0d",
                       out_data.entry_echo, out_data.curve_value);
                fails++;
            end
            else
            begin
                e = curve_q.pop_front();
                if (out_data.curve_value !== e.curve_value)
                begin
                    $error("curve_value: expected %0d, actual %0d",
                           e.curve_value, out_data.curve_value);
                    fails++;
                end
                if (out_data.entry_echo !== e.entry_echo)
                begin
                    $error("entry_echo: expected %0d, actual %0d",
                           e.entry_echo, out_data.entry_echo);
                    fails++;
                end
            end
        end
        if (hold_len > 0)
        begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            st = 1'b1;
        end
        else
        begin
            st = ($urandom_range(99) < recv_stall_pct);
        end
        out_stall <= st;
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= WatchLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic cfg_write(logic [0:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_LUT_SIZE)
            tbl_size = val[12:0];
        else
            knot_cnt = val[4:0];
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || in_valid || curve_q.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic push_load(int slot, int x, int y);
        in_word_t w;
        w = in_word_t'(InW'({$urandom, $urandom}));
        w.op          = OP_LOAD;
        w.point_index = 4'(slot);
        w.point_x     = 16'(x);
        w.point_y     = 16'(y);
        pend_q = {pend_q, w};
    endtask

    task automatic push_eval(int entry);
        in_word_t w;
        w = in_word_t'(InW'({$urandom, $urandom}));
        w.op          = OP_EVAL;
        w.entry_index = 12'(entry);
        pend_q = {pend_q, w};
    endtask

    task automatic load_sorted();
        int xs[MaxPoints];
        xs[0] = $urandom_range(4000);
        for (int k = 1; k < MaxPoints; k++)
            xs[k] = xs[k - 1] + $urandom_range(4400);
        for (int k = 0; k < MaxPoints; k++)
            push_load(k, (xs[k] > 32768) ? 32768 : xs[k], $urandom_range(32768));
    endtask

    task automatic random_words(int count, int eff_size);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < 12)
                push_load($urandom_range(15), $urandom_range(65535),
                          $urandom_range(65535));
            else if ($urandom_range(99) < 80)
                push_eval($urandom_range(eff_size - 1));
            else
                push_eval($urandom_range(4095));
        end
    endtask

    initial
    begin
        int sizes[8];
        int counts[8];
        int eff;
        sizes  = '{2, 4096, 0, 8191, 17, 1000, 3, 256};
        counts = '{2, 16, 5, 31, 1, 3, 0, 8};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity ramp at reset settings
        push_eval(0);
        push_eval(255);
        push_eval(256);
        push_eval(4095);
        push_eval(128);
        // overshooting and duplicated knots
        for (int k = 0; k < MaxPoints; k++)
            push_load(k, (k == 15) ? 32768 : (k == 1) ? 0 : k * 2184,
                      (k % 3 == 0) ? 65535 : (k % 3 == 1) ? 0 : 32768);
        drain();
        cfg_write(CFG_POINT_COUNT, 16'd16);
        push_eval(0);
        push_eval(1);
        push_eval(255);
        push_eval(4095);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            cfg_write(CFG_LUT_SIZE,
                      16'(sizes[p]) | {3'($urandom_range(7)), 13'd0});
            cfg_write(CFG_POINT_COUNT,
                      16'(counts[p]) | {11'($urandom_range(2047)), 5'd0});
            case (p % 5)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                3: begin send_idle_pct = 36; recv_stall_pct = 36; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (p == 4) hold_len = 3000;
            eff = (sizes[p] < 2) ? 2 : (sizes[p] > MaxTableSize) ? MaxTableSize : sizes[p];
            load_sorted();
            random_words(150, eff);
            drain();
        end

        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/crtc_pkg.sv
hw/rtl/crtc_datapath.sv
hw/rtl/crtc_control.sv
hw/rtl/catmull_rom_tone_curve_lut.sv
hw/rtl/crtc_checker.sv
bench/tb.sv
